// ===== src/ovfm_pkg.sv =====
// Shared types and constants for the offset vote fingerprint matcher.
package ovfm_pkg;

  localparam int SAMPLE_DEPTH_DEF = 256;
  localparam int SONG_DEPTH_DEF   = 4096;
  localparam int MAX_SONGS_DEF    = 65536;
  localparam int QUEUE_DEPTH      = 4;

  localparam int QW        = 23;
  localparam int RECIP_W   = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int RECIP_SHIFT = 38;
  localparam int VW        = 9;
  localparam logic [VW-1:0] VOTE_MAX = 9'd511;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_SONG   = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  localparam logic KIND_SCORE = 1'b0;
  localparam logic KIND_BEST  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] hash_value;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] song_index;
    logic [8:0]  vote_count;
    logic [8:0]  sample_length;
    logic        no_songs;
  } result_t;

  typedef struct packed {
    logic [1:0]    command;
    logic [QW-1:0] qvalue;
  } qitem_t;

endpackage

// ===== src/ovfm_front.sv =====
// Front end: accept items and quantize the hash word by division by 1000.
module ovfm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  ovfm_pkg::item_t     item,
  output logic                push,
  input  logic                full,
  output ovfm_pkg::qitem_t    qitem
);

  localparam int PW = 32 + ovfm_pkg::RECIP_W;

  logic                busy;
  logic                phase;
  ovfm_pkg::item_t     hold;
  logic [PW-1:0]       prod;

  assign stall = busy;
  assign push  = busy && phase && !full;
  assign qitem.command = hold.command;
  assign qitem.qvalue  = prod[ovfm_pkg::RECIP_SHIFT +: ovfm_pkg::QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (!busy) begin
      if (valid) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end
    end else if (!phase) begin
      phase <= 1'b1;
    end else if (!full) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && valid) begin
      hold <= item;
    end
    if (busy && !phase) begin
      prod <= PW'(hold.hash_value) * PW'(ovfm_pkg::RECIP_1000);
    end
  end

endmodule

// ===== src/ovfm_queue.sv =====
// Short queue of classified items between front and back.
module ovfm_queue #(
  parameter int DEPTH = ovfm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ovfm_pkg::qitem_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output ovfm_pkg::qitem_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ovfm_pkg::qitem_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : AW'(wptr + 1'b1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : AW'(rptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== src/ovfm_back.sv =====
// Back end: sample store, offset histogram, scoring and result register.
module ovfm_back #(
  parameter int SAMPLE_DEPTH = ovfm_pkg::SAMPLE_DEPTH_DEF,
  parameter int SONG_DEPTH   = ovfm_pkg::SONG_DEPTH_DEF,
  parameter int MAX_SONGS    = ovfm_pkg::MAX_SONGS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  ovfm_pkg::qitem_t   qitem,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output ovfm_pkg::result_t  result
);

  localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CW  = $clog2(SAMPLE_DEPTH + 1);
  localparam int PW  = $clog2(SONG_DEPTH + 1);
  localparam int HD  = SONG_DEPTH + SAMPLE_DEPTH;
  localparam int HW  = $clog2(HD);
  localparam int SCW = $clog2(MAX_SONGS + 1);
  localparam int QW  = ovfm_pkg::QW;
  localparam int VW  = ovfm_pkg::VW;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [QW-1:0] smem [SAMPLE_DEPTH];
  logic [VW-1:0] hmem [HD];

  logic [2:0]     state;
  logic [HW-1:0]  clr_addr;
  logic [CW-1:0]  sample_count;
  logic [PW-1:0]  song_position;
  logic [VW-1:0]  current_max_votes;
  logic [SCW-1:0] song_counter;
  logic [15:0]    best_song;
  logic [VW-1:0]  best_votes;
  logic [SAW-1:0] idx;
  logic [1:0]     cur_cmd;
  logic [QW-1:0]  cur_q;
  logic [QW-1:0]  s_q;
  logic [VW-1:0]  h_q;

  logic [HW-1:0]  bin;
  logic [VW-1:0]  v_next;
  logic           last;
  logic           out_free;
  logic           h_we;
  logic [HW-1:0]  h_waddr;
  logic [VW-1:0]  h_wdata;

  assign bin      = HW'(HW'(song_position) + HW'(SAMPLE_DEPTH - 1) - HW'(idx));
  assign v_next   = (h_q < ovfm_pkg::VOTE_MAX) ? VW'(h_q + 1'b1) : h_q;
  assign last     = (CW'(CW'(idx) + 1'b1) == sample_count);
  assign out_free = !result_valid || !result_stall;
  assign pop      = (state == ST_IDLE) && !empty;

  always_comb begin
    h_we    = 1'b0;
    h_waddr = bin;
    h_wdata = v_next;
    if (state == ST_CLR) begin
      h_we    = 1'b1;
      h_waddr = clr_addr;
      h_wdata = '0;
    end else if (state == ST_UPD) begin
      h_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (state == ST_CMP) begin
      h_q <= hmem[bin];
    end
    if (state == ST_RD) begin
      s_q <= smem[idx];
    end
    if (pop && qitem.command == ovfm_pkg::CMD_SAMPLE && sample_count < CW'(SAMPLE_DEPTH)) begin
      smem[SAW'(sample_count)] <= qitem.qvalue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLR;
      clr_addr          <= '0;
      sample_count      <= '0;
      song_position     <= '0;
      current_max_votes <= '0;
      song_counter      <= '0;
      best_song         <= '0;
      best_votes        <= '0;
      idx               <= '0;
      cur_cmd           <= ovfm_pkg::CMD_SAMPLE;
      cur_q             <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != ST_EMIT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          song_position     <= '0;
          current_max_votes <= '0;
          if (clr_addr == HW'(HD - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= HW'(clr_addr + 1'b1);
          end
        end
        ST_IDLE: begin
          if (!empty) begin
            cur_cmd <= qitem.command;
            cur_q   <= qitem.qvalue;
            unique case (qitem.command)
              ovfm_pkg::CMD_SAMPLE: begin
                if (sample_count < CW'(SAMPLE_DEPTH)) begin
                  sample_count <= CW'(sample_count + 1'b1);
                end
              end
              ovfm_pkg::CMD_SONG: begin
                if (song_position < PW'(SONG_DEPTH)) begin
                  if (sample_count == '0) begin
                    song_position <= PW'(song_position + 1'b1);
                  end else begin
                    idx   <= '0;
                    state <= ST_RD;
                  end
                end
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (s_q == cur_q) begin
            state <= ST_UPD;
          end else if (last) begin
            song_position <= PW'(song_position + 1'b1);
            state         <= ST_IDLE;
          end else begin
            idx   <= SAW'(idx + 1'b1);
            state <= ST_RD;
          end
        end
        ST_UPD: begin
          if (v_next > current_max_votes) begin
            current_max_votes <= v_next;
          end
          if (last) begin
            song_position <= PW'(song_position + 1'b1);
            state         <= ST_IDLE;
          end else begin
            idx   <= SAW'(idx + 1'b1);
            state <= ST_RD;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            clr_addr <= '0;
            state    <= ST_CLR;
            result.sample_length <= 9'(sample_count);
            if (cur_cmd == ovfm_pkg::CMD_END) begin
              if (song_counter < SCW'(MAX_SONGS)) begin
                result_valid      <= 1'b1;
                result.kind       <= ovfm_pkg::KIND_SCORE;
                result.song_index <= 16'(song_counter);
                result.vote_count <= current_max_votes;
                result.no_songs   <= 1'b0;
                if (song_counter == '0 || current_max_votes > best_votes) begin
                  best_song  <= 16'(song_counter);
                  best_votes <= current_max_votes;
                end
                song_counter <= SCW'(song_counter + 1'b1);
              end else begin
                result_valid <= 1'b0;
              end
            end else begin
              result_valid <= 1'b1;
              result.kind  <= ovfm_pkg::KIND_BEST;
              if (song_counter == '0) begin
                result.song_index <= '0;
                result.vote_count <= '0;
                result.no_songs   <= 1'b1;
              end else begin
                result.song_index <= best_song;
                result.vote_count <= best_votes;
                result.no_songs   <= 1'b0;
              end
              sample_count <= '0;
              song_counter <= '0;
              best_song    <= '0;
              best_votes   <= '0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/offset_vote_fingerprint_match.sv =====
// Top level: offset vote fingerprint matcher.
// Front takes one transaction at a time: it stalls new items while it quantizes one and
// pushes it into the queue. Song value: the back end steps through each loaded sample
// value in read and compare states, with an update state added per match.
// End of song and report: result registered in the emit state once the output is free,
// then a histogram clearing pass over SONG_DEPTH + SAMPLE_DEPTH bins. Reset runs it too.
module offset_vote_fingerprint_match #(
  parameter int SAMPLE_DEPTH = ovfm_pkg::SAMPLE_DEPTH_DEF,
  parameter int SONG_DEPTH   = ovfm_pkg::SONG_DEPTH_DEF,
  parameter int MAX_SONGS    = ovfm_pkg::MAX_SONGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ovfm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ovfm_pkg::result_t result
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  ovfm_pkg::qitem_t q_wdata;
  ovfm_pkg::qitem_t q_rdata;

  ovfm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .valid (item_valid),
    .stall (item_stall),
    .item  (item),
    .push  (q_push),
    .full  (q_full),
    .qitem (q_wdata)
  );

  ovfm_queue #(
    .DEPTH (ovfm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  ovfm_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .SONG_DEPTH   (SONG_DEPTH),
    .MAX_SONGS    (MAX_SONGS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .qitem        (q_rdata),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
